>>> design/mp2w_pkg.sv
// Shared types and constants for the 2-D max pooling window block.
package mp2w_pkg;

    localparam int COORD_W    = 12;
    localparam int DIM_W      = 7;
    localparam int KSZ_W      = 4;
    localparam int ROW_W      = 6;
    localparam int SAMPLE_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int MAX_KERNEL = 8;

    localparam logic signed [SAMPLE_W-1:0] PAD_VALUE = 16'sh8000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IN_HEIGHT  = 3'd0,
        REG_IN_WIDTH   = 3'd1,
        REG_OUT_HEIGHT = 3'd2,
        REG_OUT_WIDTH  = 3'd3,
        REG_KERNEL     = 3'd4,
        REG_STRIDE     = 3'd5,
        REG_PADDING    = 3'd6
    } reg_idx_t;

    typedef enum logic {
        MODE_LOAD  = 1'b0,
        MODE_QUERY = 1'b1
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } seq_state_t;

    typedef struct packed {
        logic [DIM_W-1:0] in_height;
        logic [DIM_W-1:0] in_width;
        logic [DIM_W-1:0] out_height;
        logic [DIM_W-1:0] out_width;
        logic [KSZ_W-1:0] kernel;
        logic [KSZ_W-1:0] stride;
        logic [2:0]       half_pad;
    } pool_cfg_t;

    typedef struct packed {
        logic clear;
        logic issue;
        logic in_plane;
        logic emit;
        logic err;
    } seq_ctl_t;

endpackage

>>> design/mp2w_plane_mem.sv
// Plane store: one write port, one registered read port.
module mp2w_plane_mem
    import mp2w_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
)
(
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [AW-1:0]              wr_addr,
    input  logic signed [SAMPLE_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [AW-1:0]              rd_addr,
    output logic signed [SAMPLE_W-1:0] rd_data
);

    logic signed [SAMPLE_W-1:0] mem [DEPTH];
    logic signed [SAMPLE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/mp2w_max_unit.sv
// Shared compare unit: running maximum over the samples of one window.
module mp2w_max_unit
    import mp2w_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  seq_ctl_t                   ctl,
    input  logic signed [SAMPLE_W-1:0] rd_data,
    output logic signed [SAMPLE_W-1:0] best
);

    logic                       vld_reg;
    logic                       in_plane_reg;
    logic signed [SAMPLE_W-1:0] best_reg;
    logic signed [SAMPLE_W-1:0] best_next;
    logic signed [SAMPLE_W-1:0] cand;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= 1'b0;
            in_plane_reg <= 1'b0;
        end
        else
        begin
            vld_reg      <= ctl.issue;
            in_plane_reg <= ctl.in_plane;
        end
    end

    always_comb
    begin
        cand      = in_plane_reg ? rd_data : PAD_VALUE;
        best_next = best_reg;
        if (ctl.clear)
        begin
            best_next = PAD_VALUE;
        end
        else if (vld_reg && (cand > best_reg))
        begin
            best_next = cand;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg <= best_next;
    end

    assign best = best_reg;

endmodule

>>> design/mp2w_seq.sv
// Window sequencer: walks the kernel rows and columns and issues plane reads.
module mp2w_seq
    import mp2w_pkg::*;
#(
    parameter int MAX_WIDTH = 64,
    parameter int AW        = 12
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  pool_cfg_t        cfg,
    input  logic             in_valid,
    input  logic             mode,
    input  logic [ROW_W-1:0] row,
    input  logic [ROW_W-1:0] col,
    input  logic             out_free,
    output logic             in_ready,
    output logic [AW-1:0]    rd_addr,
    output seq_ctl_t         ctl
);

    localparam int EXT_W = AW + COORD_W;

    seq_state_t                 state_reg, state_next;
    logic [KSZ_W-1:0]           n_reg, n_next;
    logic [KSZ_W-1:0]           m_reg, m_next;
    logic signed [COORD_W-1:0]  base_h_reg, base_h_next;
    logic signed [COORD_W-1:0]  base_w_reg, base_w_next;
    logic                       err_reg, err_next;
    logic signed [COORD_W-1:0]  h;
    logic signed [COORD_W-1:0]  w;
    logic signed [COORD_W-1:0]  org_h;
    logic signed [COORD_W-1:0]  org_w;
    logic                       in_plane;
    logic                       out_of_range;
    logic                       last_n;
    logic                       last_m;
    logic [KSZ_W-1:0]           k_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        m_reg      <= m_next;
        base_h_reg <= base_h_next;
        base_w_reg <= base_w_next;
        err_reg    <= err_next;
    end

    always_comb
    begin
        org_h = signed'(COORD_W'(row) * COORD_W'(cfg.stride)) - signed'(COORD_W'(cfg.half_pad));
        org_w = signed'(COORD_W'(col) * COORD_W'(cfg.stride)) - signed'(COORD_W'(cfg.half_pad));
        h = base_h_reg + signed'(COORD_W'(n_reg));
        w = base_w_reg + signed'(COORD_W'(m_reg));
        in_plane = (h >= 0) && (h < signed'(COORD_W'(cfg.in_height)))
                && (w >= 0) && (w < signed'(COORD_W'(cfg.in_width)));
        rd_addr = AW'(EXT_W'(unsigned'(h)) * EXT_W'(MAX_WIDTH) + EXT_W'(unsigned'(w)));
        out_of_range = ({1'b0, row} >= cfg.out_height) || ({1'b0, col} >= cfg.out_width);
        k_last = cfg.kernel - KSZ_W'(1);
        last_n = (n_reg == k_last);
        last_m = (m_reg == k_last);
    end

    always_comb
    begin
        state_next   = state_reg;
        n_next       = n_reg;
        m_next       = m_reg;
        base_h_next  = base_h_reg;
        base_w_next  = base_w_reg;
        err_next     = err_reg;
        in_ready     = 1'b0;
        ctl          = '0;
        ctl.in_plane = in_plane;
        ctl.err      = err_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && (mode == MODE_QUERY))
                begin
                    ctl.clear   = 1'b1;
                    n_next      = '0;
                    m_next      = '0;
                    base_h_next = org_h;
                    base_w_next = org_w;
                    err_next    = out_of_range;
                    if (out_of_range || (cfg.kernel == '0))
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                ctl.issue = 1'b1;
                if (last_m)
                begin
                    m_next = '0;
                    if (last_n)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        n_next = n_reg + KSZ_W'(1);
                    end
                end
                else
                begin
                    m_next = m_reg + KSZ_W'(1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    ctl.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_scan_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> ((n_reg < cfg.kernel) && (m_reg < cfg.kernel)))
        else $error("window counter beyond kernel");

    a_scan_ends_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) && last_n && last_m |=> (state_reg == ST_DRAIN))
        else $error("scan did not drain after last tap");

    a_emit_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.emit |=> (state_reg == ST_IDLE) && in_ready)
        else $error("sequencer not idle after result");

    a_error_skips_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) && in_valid && (mode == MODE_QUERY) && out_of_range
        |=> (state_reg == ST_DONE) && err_reg)
        else $error("flagged query entered scan");

endmodule

>>> design/max_pool_2d_window.sv
// Top level of the 2-D max pooling window block: configuration, load path, result register.
//
// Input channel (in_valid/in_ready): mode selects a load or a query. A load writes
// sample into the plane store at (row, col) in the accepting cycle and gives no
// result; loads outside the plane in use are dropped. A query names an output
// position and gives one result on the output channel (out_valid/out_ready).
// A query reads each tap of its kernel_size by kernel_size window, one read per cycle on
// the single read port of the plane store, then passes through read, compare and
// hand-off into the output register; no new item is taken before that hand-off. A
// flagged query or a zero kernel skips the plane reads and goes straight to hand-off.
// Loads are taken only while no query is in progress. The output register holds a
// finished result while the receiver stalls; the block takes loads and starts the
// next query meanwhile and waits with that query's result until the register is free.
// Reset clears the control state and restores the register defaults; the plane
// store is not cleared and an entry holds no defined value until it is written.
// Configuration writes (cfg_we, cfg_addr, cfg_wdata) take effect at once and are
// to be made only while no query is in flight.
module max_pool_2d_window
    import mp2w_pkg::*;
#(
    parameter int MAX_HEIGHT = 64,
    parameter int MAX_WIDTH  = 64
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_addr,
    input  logic [DIM_W-1:0]           cfg_wdata,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       mode,
    input  logic [ROW_W-1:0]           row,
    input  logic [ROW_W-1:0]           col,
    input  logic signed [SAMPLE_W-1:0] sample,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] max_value,
    output logic                       error
);

    localparam int DEPTH = MAX_HEIGHT * MAX_WIDTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int EXT_W = AW + COORD_W;

    logic [DIM_W-1:0]           in_height_reg;
    logic [DIM_W-1:0]           in_width_reg;
    logic [DIM_W-1:0]           out_height_reg;
    logic [DIM_W-1:0]           out_width_reg;
    logic [KSZ_W-1:0]           kernel_reg;
    logic [KSZ_W-1:0]           stride_reg;
    logic [KSZ_W-1:0]           padding_reg;
    pool_cfg_t                  cfg;
    seq_ctl_t                   ctl;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] max_value_reg;
    logic                       error_reg;
    logic                       out_free;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic [AW-1:0]              rd_addr;
    logic signed [SAMPLE_W-1:0] rd_data;
    logic signed [SAMPLE_W-1:0] best;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_height_reg  <= 7'd64;
            in_width_reg   <= 7'd64;
            out_height_reg <= 7'd32;
            out_width_reg  <= 7'd32;
            kernel_reg     <= 4'd2;
            stride_reg     <= 4'd2;
            padding_reg    <= 4'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_IN_HEIGHT:  in_height_reg  <= cfg_wdata;
                REG_IN_WIDTH:   in_width_reg   <= cfg_wdata;
                REG_OUT_HEIGHT: out_height_reg <= cfg_wdata;
                REG_OUT_WIDTH:  out_width_reg  <= cfg_wdata;
                REG_KERNEL:     kernel_reg     <= cfg_wdata[KSZ_W-1:0];
                REG_STRIDE:     stride_reg     <= cfg_wdata[KSZ_W-1:0];
                REG_PADDING:    padding_reg    <= cfg_wdata[KSZ_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        cfg.in_height  = (32'(in_height_reg) > 32'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT)
                                                                 : in_height_reg;
        cfg.in_width   = (32'(in_width_reg) > 32'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH)
                                                               : in_width_reg;
        cfg.out_height = out_height_reg;
        cfg.out_width  = out_width_reg;
        cfg.kernel     = (32'(kernel_reg) > 32'(MAX_KERNEL)) ? KSZ_W'(MAX_KERNEL)
                                                              : kernel_reg;
        cfg.stride     = stride_reg;
        cfg.half_pad   = padding_reg[KSZ_W-1:1];
    end

    assign wr_en   = in_valid && in_ready && (mode == MODE_LOAD)
                  && ({1'b0, row} < cfg.in_height) && ({1'b0, col} < cfg.in_width);
    assign wr_addr = AW'(EXT_W'(row) * EXT_W'(MAX_WIDTH) + EXT_W'(col));
    assign out_free = !out_valid_reg || out_ready;

    mp2w_seq #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (in_valid),
        .mode     (mode),
        .row      (row),
        .col      (col),
        .out_free (out_free),
        .in_ready (in_ready),
        .rd_addr  (rd_addr),
        .ctl      (ctl)
    );

    mp2w_plane_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_plane_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (sample),
        .rd_en   (ctl.issue),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    mp2w_max_unit u_max_unit (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .rd_data (rd_data),
        .best    (best)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            max_value_reg <= ctl.err ? '0 : best;
            error_reg     <= ctl.err;
        end
    end

    assign out_valid = out_valid_reg;
    assign max_value = max_value_reg;
    assign error     = error_reg;

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the 2-D max pooling window block: loads and queries.
module testbench;
    import mp2w_pkg::*;

    localparam int PLANE_ROWS = 64;
    localparam int PLANE_COLS = 64;
    localparam int SETTLE_CYCLES = 80;
    localparam int HOLD_CYCLES = 300;
    localparam int ITEMS_PER_PHASE = 40;
    localparam int PHASES = 12;

    typedef struct packed {
        mode_t                       mode;
        logic [ROW_W-1:0]            row;
        logic [ROW_W-1:0]            col;
        logic signed [SAMPLE_W-1:0]  sample;
    } pool_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0]  max_value;
        logic                        error;
    } pool_answer_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_addr = '0;
    logic [DIM_W-1:0]           cfg_wdata = '0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    mode_t                      mode = MODE_LOAD;
    logic [ROW_W-1:0]           row = '0;
    logic [ROW_W-1:0]           col = '0;
    logic signed [SAMPLE_W-1:0] sample = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] max_value;
    logic                       error;

    int cfg_in_h = 64;
    int cfg_in_w = 64;
    int cfg_out_h = 32;
    int cfg_out_w = 32;
    int cfg_kernel = 2;
    int cfg_stride = 2;
    int cfg_pad = 0;

    logic signed [SAMPLE_W-1:0] plane_copy [0:PLANE_ROWS*PLANE_COLS-1];
    bit                         written_map [0:PLANE_ROWS*PLANE_COLS-1];

    pool_item_t   item_backlog [$];
    pool_answer_t pending_maxima [$];
    pool_item_t   next_item;
    pool_answer_t oldest_max;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int send_wait = 0;
    int recv_wait = 0;
    int recv_draw = 0;
    int hold_left = 0;

    int items_queued = 0;
    int loads_sent = 0;
    int queries_sent = 0;
    int flagged_seen = 0;
    int results_checked = 0;
    int mismatches = 0;
    int settings_used = 1;

    max_pool_2d_window dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .row       (row),
        .col       (col),
        .sample    (sample),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .max_value (max_value),
        .error     (error)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int plane_rows();
        return (cfg_in_h > PLANE_ROWS) ? PLANE_ROWS : cfg_in_h;
    endfunction

    function automatic int plane_cols();
        return (cfg_in_w > PLANE_COLS) ? PLANE_COLS : cfg_in_w;
    endfunction

    function automatic int draw_wait(int pct);
        if (pct != 0 && $urandom_range(0, 99) < pct)
            return $urandom_range(1, 18);
        return 0;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return PAD_VALUE;
            1: return 16'sh7FFF;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic int pick_coord(int limit);
        if ($urandom_range(0, 4) == 0)
            return $urandom_range(0, 63);
        return $urandom_range(0, limit - 1);
    endfunction

    function automatic pool_answer_t pool_window_max(logic [ROW_W-1:0] r, logic [ROW_W-1:0] c);
        pool_answer_t ans;
        int k;
        int off;
        int h;
        int w;
        int n;
        int m;
        int v;
        int best;
        ans.max_value = '0;
        ans.error = 1'b0;
        if (r >= cfg_out_h || c >= cfg_out_w)
        begin
            ans.error = 1'b1;
            return ans;
        end
        k = (cfg_kernel > MAX_KERNEL) ? MAX_KERNEL : cfg_kernel;
        off = cfg_pad / 2;
        best = PAD_VALUE;
        for (n = 0; n < k; n++)
        begin
            h = int'(r) * cfg_stride - off + n;
            for (m = 0; m < k; m++)
            begin
                w = int'(c) * cfg_stride - off + m;
                v = PAD_VALUE;
                if (h >= 0 && h < plane_rows() && w >= 0 && w < plane_cols())
                    v = plane_copy[h * PLANE_COLS + w];
                if (v > best)
                    best = v;
            end
        end
        ans.max_value = best[SAMPLE_W-1:0];
        return ans;
    endfunction

    task automatic absorb_item();
        if (mode == MODE_LOAD)
        begin
            loads_sent++;
            if (row < plane_rows() && col < plane_cols())
                plane_copy[{row, col}] = sample;
        end
        else
        begin
            queries_sent++;
            pending_maxima.push_back(pool_window_max(row, col));
        end
    endtask

    task automatic flag_mismatch(string what, int want, int got);
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    endtask

    task automatic check_result();
        results_checked++;
        if (error)
            flagged_seen++;
        if (pending_maxima.size() == 0)
        begin
            mismatches++;
            $display("%0t: unexpected result, expected none, got max_value %0d error %0b",
                     $time, max_value, error);
        end
        else
        begin
            oldest_max = pending_maxima.pop_front();
            if (oldest_max.error !== error)
                flag_mismatch("error", oldest_max.error, error);
            if (oldest_max.max_value !== max_value)
                flag_mismatch("max_value", $signed(oldest_max.max_value), max_value);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_wait <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                absorb_item();
            if (!in_valid || in_ready)
            begin
                if (send_wait > 0)
                begin
                    in_valid <= 1'b0;
                    send_wait <= send_wait - 1;
                end
                else if (item_backlog.size() != 0)
                begin
                    next_item = item_backlog.pop_front();
                    mode <= next_item.mode;
                    row <= next_item.row;
                    col <= next_item.col;
                    sample <= next_item.sample;
                    in_valid <= 1'b1;
                    send_wait <= draw_wait(send_idle_pct);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_wait <= 0;
            hold_left <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_result();
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left <= hold_left - 1;
            end
            else if (out_valid && out_ready)
            begin
                if (results_checked % 100 == 50)
                begin
                    // hold off long enough for the input side to back up
                    out_ready <= 1'b0;
                    hold_left <= HOLD_CYCLES;
                end
                else
                begin
                    recv_draw = draw_wait(recv_idle_pct);
                    out_ready <= (recv_draw == 0);
                    recv_wait <= (recv_draw > 0) ? recv_draw - 1 : 0;
                end
            end
            else if (recv_wait > 0)
            begin
                out_ready <= 1'b0;
                recv_wait <= recv_wait - 1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic write_reg(reg_idx_t idx, int value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= DIM_W'(value);
        case (idx)
            REG_IN_HEIGHT:  cfg_in_h = value;
            REG_IN_WIDTH:   cfg_in_w = value;
            REG_OUT_HEIGHT: cfg_out_h = value;
            REG_OUT_WIDTH:  cfg_out_w = value;
            REG_KERNEL:     cfg_kernel = value;
            REG_STRIDE:     cfg_stride = value;
            REG_PADDING:    cfg_pad = value;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_setting(int ih, int iw, int oh, int ow, int k, int s, int pd);
        write_reg(REG_IN_HEIGHT, ih);
        write_reg(REG_IN_WIDTH, iw);
        write_reg(REG_OUT_HEIGHT, oh);
        write_reg(REG_OUT_WIDTH, ow);
        write_reg(REG_KERNEL, k);
        write_reg(REG_STRIDE, s);
        write_reg(REG_PADDING, pd);
        settings_used++;
        @(negedge clk);
    endtask

    task automatic queue_load(int r, int c, logic signed [SAMPLE_W-1:0] value);
        pool_item_t it;
        it.mode = MODE_LOAD;
        it.row = ROW_W'(r);
        it.col = ROW_W'(c);
        it.sample = value;
        if (r < plane_rows() && c < plane_cols())
            written_map[r * PLANE_COLS + c] = 1'b1;
        item_backlog.push_back(it);
        items_queued++;
    endtask

    task automatic queue_query(int r, int c);
        pool_item_t it;
        int off;
        int h;
        int w;
        int n;
        int m;
        // fill any never-written cell the window touches inside the plane
        if (r < cfg_out_h && c < cfg_out_w)
        begin
            off = cfg_pad / 2;
            for (n = 0; n < cfg_kernel; n++)
            begin
                for (m = 0; m < cfg_kernel; m++)
                begin
                    h = r * cfg_stride - off + n;
                    w = c * cfg_stride - off + m;
                    if (h >= 0 && h < plane_rows() && w >= 0 && w < plane_cols()
                        && !written_map[h * PLANE_COLS + w])
                        queue_load(h, w, rand_sample());
                end
            end
        end
        it.mode = MODE_QUERY;
        it.row = ROW_W'(r);
        it.col = ROW_W'(c);
        it.sample = rand_sample();
        item_backlog.push_back(it);
        items_queued++;
    endtask

    task automatic settle();
        @(negedge clk);
        while (item_backlog.size() != 0 || in_valid || pending_maxima.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        int p;
        int ih;
        int iw;
        int oh;
        int ow;
        int k;
        int s;
        int pd;
        int phase_base;
        int levels [3];
        levels = '{0, 25, 80};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // corners, overwrite, all-minimum window, flagged positions, far corner
        queue_load(0, 0, 16'sh7FFF);
        queue_load(0, 1, PAD_VALUE);
        queue_load(1, 0, 16'sh0001);
        queue_load(1, 1, -16'sh0001);
        queue_query(0, 0);
        queue_load(0, 0, PAD_VALUE);
        queue_query(0, 0);
        queue_load(1, 0, PAD_VALUE);
        queue_load(1, 1, PAD_VALUE);
        queue_query(0, 0);
        queue_query(32, 0);
        queue_query(0, 32);
        queue_query(63, 63);
        queue_load(63, 63, 16'sh5A5A);
        queue_query(31, 31);
        settle();

        for (p = 0; p < PHASES; p++)
        begin
            if (p == 0)
                apply_setting(1, 1, 1, 1, 1, 1, 0);
            else if (p == 1)
                apply_setting(64, 64, 64, 64, 8, 8, 15);
            else
            begin
                ih = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 12);
                iw = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 12);
                k = $urandom_range(1, 8);
                s = $urandom_range(1, 8);
                pd = $urandom_range(0, 15);
                oh = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 64)
                                                 : ih / s + $urandom_range(1, 3);
                ow = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 64)
                                                 : iw / s + $urandom_range(1, 3);
                apply_setting(ih, iw, (oh > 64) ? 64 : oh, (ow > 64) ? 64 : ow, k, s, pd);
            end
            send_idle_pct = levels[p % 3];
            recv_idle_pct = levels[(p / 3) % 3];
            phase_base = items_queued;
            while (items_queued - phase_base < ITEMS_PER_PHASE)
            begin
                if ($urandom_range(0, 99) < 35)
                    queue_load(pick_coord(cfg_in_h), pick_coord(cfg_in_w), rand_sample());
                else
                    queue_query(pick_coord(cfg_out_h), pick_coord(cfg_out_w));
            end
            settle();
        end

        $display("covered %0d loads and %0d queries (%0d flagged) across %0d register settings",
                 loads_sent, queries_sent, flagged_seen, settings_used);
        $display("checked %0d pooled results, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0 && pending_maxima.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
